// ----- design/assert_macros.svh -----
// assertion helpers used by sha512_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold whenever reset is released
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the clock, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequence is checked on the clock after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sha512_pkg.sv -----
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types, constants and functions of the SHA-512 message hash core.
// ----------------------------------------------------------------------------
package sha512_pkg;

    localparam int WordBits  = 64;
    localparam int BlockWrds = 16;
    localparam int Rounds    = 80;

    typedef logic [WordBits-1:0] t_word;

    // commands from the controller to the datapath
    typedef struct packed {
        logic absorb;     // merge input bytes into the block buffer
        logic pad;        // write the 0x80 marker and clear the tail
        logic zero_blk;   // clear the whole block buffer
        logic put_len;    // write the length field into words 14 and 15
        logic start_cmp;  // load working registers from the chaining value
        logic round;      // run one compression round
        logic fold;       // add working registers into the chaining value
        logic rst_hash;   // return chaining value, fill level and length to start
        logic [6:0] rnd;  // round number
        logic [2:0] out_sel; // digest word to present
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic blk_full;   // last absorb filled the buffer
        logic pad_extra;  // padding needs an extra block
    } t_stat;

    localparam t_word StartHash [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam t_word RoundK [Rounds] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (WordBits - n));
    endfunction

endpackage

// ----- design/sha512_ctrl.sv -----
// ----------------------------------------------------------------------------
// sha512_ctrl
// Sequencer: absorb, compress on full block, pad, final compressions, output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha512_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_last_item,
    output logic               o_stall,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output sha512_pkg::t_cmd   o_cmd,
    input  sha512_pkg::t_stat  i_stat
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CHECK = 8'b0000_0010,
        ST_PAD   = 8'b0000_0100,
        ST_INIT  = 8'b0000_1000,
        ST_ROUND = 8'b0001_0000,
        ST_FOLD  = 8'b0010_0000,
        ST_LEN   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } t_state;

    // phase of the block being compressed
    typedef enum logic [1:0] {
        PH_DATA  = 2'd0,
        PH_EXTRA = 2'd1,
        PH_FINAL = 2'd2
    } t_phase;

    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    logic       r_last, n_last;
    logic [6:0] r_rnd, n_rnd;
    logic [2:0] r_out, n_out;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_last  = r_last;
        n_rnd   = r_rnd;
        n_out   = r_out;
        o_cmd   = '0;
        o_cmd.rnd     = r_rnd;
        o_cmd.out_sel = r_out;
        o_stall     = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.absorb = 1'b1;
                    n_last  = i_last_item;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.blk_full) begin
                    n_phase = PH_DATA;
                    n_state = ST_INIT;
                end else if (r_last) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                o_cmd.pad = 1'b1;
                if (i_stat.pad_extra) begin
                    n_phase = PH_EXTRA;
                    n_state = ST_INIT;
                end else begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                o_cmd.put_len = 1'b1;
                n_phase = PH_FINAL;
                n_state = ST_INIT;
            end
            ST_INIT: begin
                o_cmd.start_cmp = 1'b1;
                n_rnd   = '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_rnd = r_rnd + 7'd1;
                if (r_rnd == 7'(sha512_pkg::Rounds - 1)) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                o_cmd.fold = 1'b1;
                case (r_phase)
                    PH_DATA:  n_state = r_last ? ST_PAD : ST_IDLE;
                    PH_EXTRA: begin
                        o_cmd.zero_blk = 1'b1;
                        n_state = ST_LEN;
                    end
                    default: begin
                        n_out   = '0;
                        n_state = ST_OUT;
                    end
                endcase
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_out = r_out + 3'd1;
                    if (r_out == 3'd7) begin
                        o_cmd.rst_hash = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_DATA;
            r_last  <= 1'b0;
            r_rnd   <= '0;
            r_out   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_last  <= n_last;
            r_rnd   <= n_rnd;
            r_out   <= n_out;
        end
    end

    `ASSERT_IMPLY(a_round_range, i_clk, i_rst_n, r_state == ST_ROUND, r_rnd < 7'd80, "round count out of range")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(r_out), "digest word dropped under stall")
    `ASSERT_IMPLY(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE, o_stall, "input accepted while busy")

endmodule

// ----- design/sha512_dp.sv -----
// ----------------------------------------------------------------------------
// sha512_dp
// Datapath: block buffer, message schedule, round logic, chaining value.
// ----------------------------------------------------------------------------
module sha512_dp #(
    parameter int LENGTH_COUNTER_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [63:0]        i_message_word,
    input  logic [3:0]         i_byte_count,
    input  sha512_pkg::t_cmd   i_cmd,
    output sha512_pkg::t_stat  o_stat,
    output logic [63:0]        o_digest_word
);

    localparam int LenW = LENGTH_COUNTER_BITS;

    sha512_pkg::t_word r_buf [16];
    sha512_pkg::t_word r_w   [16];
    sha512_pkg::t_word r_h   [8];
    sha512_pkg::t_word r_v   [8];
    sha512_pkg::t_word r_spill;
    logic [6:0]        r_fill;
    logic [LenW-1:0]   r_len;
    logic              r_full;

    logic [3:0]        cnt;
    logic [7:0]        fill_sum;
    logic [127:0]      merged, kept, add_mask;
    logic [127:0]      cur_pair;
    logic [63:0]       in_mask;
    sha512_pkg::t_word wt, s0, s1, t1, t2, w_next;
    logic [127:0]      bitlen;

    // valid byte count clipped to eight
    assign cnt      = (i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
    assign fill_sum = {1'b0, r_fill} + {4'd0, cnt};

    // new bytes land in a two-word window starting at the fill word
    always_comb begin
        in_mask  = (cnt == 4'd0) ? 64'd0 : ~(64'hFFFF_FFFF_FFFF_FFFF >> {cnt, 3'b000});
        cur_pair = {r_buf[r_fill[6:3]], r_buf[r_fill[6:3] + 4'd1]};
        add_mask = {in_mask, 64'd0} >> {r_fill[2:0], 3'b000};
        kept     = ~(128'hFFFF_FFFF_FFFF_FFFF_0000_0000_0000_0000 >> {r_fill[2:0], 3'b000})
                   & cur_pair;
        merged   = kept | (({i_message_word & in_mask, 64'd0} >> {r_fill[2:0], 3'b000})
                   & add_mask);
    end

    assign o_stat.blk_full  = r_full;
    assign o_stat.pad_extra = (r_fill > 7'd111);
    assign bitlen = {64'd0, 64'(r_len)} << 3;

    // round function
    assign wt = r_w[0];
    assign s0 = sha512_pkg::rotr(r_w[1], 1) ^ sha512_pkg::rotr(r_w[1], 8) ^ (r_w[1] >> 7);
    assign s1 = sha512_pkg::rotr(r_w[14], 19) ^ sha512_pkg::rotr(r_w[14], 61)
              ^ (r_w[14] >> 6);
    assign w_next = r_w[0] + s0 + r_w[9] + s1;
    assign t1 = r_v[7] + (sha512_pkg::rotr(r_v[4], 14) ^ sha512_pkg::rotr(r_v[4], 18)
              ^ sha512_pkg::rotr(r_v[4], 41)) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + sha512_pkg::RoundK[i_cmd.rnd] + wt;
    assign t2 = (sha512_pkg::rotr(r_v[0], 28) ^ sha512_pkg::rotr(r_v[0], 34)
              ^ sha512_pkg::rotr(r_v[0], 39))
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    assign o_digest_word = r_h[i_cmd.out_sel];

    // block buffer, schedule and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.absorb) begin
            r_buf[r_fill[6:3]] <= merged[127:64];
            if (r_fill[2:0] != 3'd0 && r_fill[6:3] != 4'd15) begin
                r_buf[r_fill[6:3] + 4'd1] <= merged[63:0];
            end
            // bytes past the block end wait until the block is copied out
            if (r_fill[6:3] == 4'd15) begin
                r_spill <= merged[63:0];
            end
        end
        if (i_cmd.pad) begin
            for (int i = 0; i < 16; i++) begin
                if (4'(i) > r_fill[6:3]) r_buf[i] <= '0;
            end
            r_buf[r_fill[6:3]] <= (r_buf[r_fill[6:3]]
                & ~(64'hFFFF_FFFF_FFFF_FFFF >> {r_fill[2:0], 3'b000}))
                | (64'h8000_0000_0000_0000 >> {r_fill[2:0], 3'b000});
        end
        if (i_cmd.zero_blk) begin
            for (int i = 0; i < 16; i++) r_buf[i] <= '0;
        end
        if (i_cmd.put_len) begin
            r_buf[14] <= bitlen[127:64];
            r_buf[15] <= bitlen[63:0];
        end
        if (i_cmd.start_cmp) begin
            for (int i = 0; i < 16; i++) r_w[i] <= r_buf[i];
            for (int i = 0; i < 8; i++)  r_v[i] <= r_h[i];
            // carried bytes start the next block
            if (r_full) r_buf[0] <= r_spill;
        end
        if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_next;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    // chaining value, fill level and message length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_h[i] <= sha512_pkg::StartHash[i];
            r_fill <= '0;
            r_len  <= '0;
            r_full <= 1'b0;
        end else begin
            if (i_cmd.absorb) begin
                r_fill <= fill_sum[6:0];
                r_len  <= r_len + LenW'(cnt);
                r_full <= fill_sum[7];
            end
            if (i_cmd.start_cmp) r_full <= 1'b0;
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            if (i_cmd.rst_hash) begin
                for (int i = 0; i < 8; i++) r_h[i] <= sha512_pkg::StartHash[i];
                r_fill <= '0;
                r_len  <= '0;
            end
        end
    end

endmodule

// ----- design/sha512_message_hash_core.sv -----
// ----------------------------------------------------------------------------
// sha512_message_hash_core
// SHA-512 hasher over big-endian packed message words, digest out as 8 words.
// ----------------------------------------------------------------------------
// One input transaction is taken at a time: an item that does not fill the
// 128-byte block is merged into the buffer; one that fills it also starts the
// compression, which runs one round per cycle through a single round unit.
// A last item adds padding plus one or two compressions and then eight
// output transactions, one per cycle unless stalled.
module sha512_message_hash_core #(
    parameter int LENGTH_COUNTER_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_message_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_item,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    sha512_pkg::t_cmd  cmd;
    sha512_pkg::t_stat stat;

    sha512_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_item (i_last_item),
        .o_stall     (o_stall),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    sha512_dp #(
        .LENGTH_COUNTER_BITS (LENGTH_COUNTER_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_message_word (i_message_word),
        .i_byte_count   (i_byte_count),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_digest_word  (o_digest_word)
    );

    assign o_word_index = cmd.out_sel;
    assign o_last_word  = (cmd.out_sel == 3'd7);

endmodule
